// File: hdl/ptts_pkg.sv
package ptts_pkg;

	// Operation codes
	localparam logic [2:0] OP_TICK    = 3'd0;
	localparam logic [2:0] OP_CREATE  = 3'd1;
	localparam logic [2:0] OP_DELETE  = 3'd2;
	localparam logic [2:0] OP_SUSPEND = 3'd3;
	localparam logic [2:0] OP_RESUME  = 3'd4;

	localparam int MASK_W = 8;

	// Input word
	typedef struct packed {
		logic [2:0]  operation;
		logic [2:0]  slot;
		logic [15:0] period;
		logic [15:0] first_delay;
	} in_t;

	// Result word
	typedef struct packed {
		logic              status;
		logic [MASK_W-1:0] fire_mask;
	} out_t;

	// State of one task slot, held by one cell
	typedef struct packed {
		logic        present;
		logic        resumed;
		logic [15:0] period;
		logic [15:0] countdown;
	} slot_t;

	// Per-slot outcome reported by the head update
	typedef struct packed {
		logic taken;
		logic fire;
	} upd_res_t;

	// Sequencer states
	typedef enum logic [1:0] {
		S_IDLE,
		S_RUN,
		S_DONE
	} state_t;

endpackage

// File: hdl/periodic_task_tick_scheduler_unit.sv
// Channel  Signals                          Direction  Word
// in       in_valid / in_ready / in_data    input      operation, slot, period, first_delay
// out      out_valid / out_ready / out_data output     status, fire_mask
//
// For each word the slot ring rotates once through the
// single head update unit, one slot per cycle, then the result moves to the
// output register. A new word is taken while an earlier result waits there.
// Reset clears all slots (empty, suspended, zero period and countdown).
// A stalled output holds the sequencer in its final state; the ring stays put.
module periodic_task_tick_scheduler_unit #(
	parameter int SLOT_COUNT = 8
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  ptts_pkg::in_t  in_data,
	output logic           out_valid,
	input  logic           out_ready,
	output ptts_pkg::out_t out_data
);
	import ptts_pkg::*;

	localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

	state_t             state_q, state_d;
	logic [IDX_W-1:0]   cnt_q;
	logic               last;
	in_t                item_q;
	logic [MASK_W-1:0]  mask_q;
	logic               status_q;
	out_t               out_q;
	logic               out_valid_q;
	logic               shift_en;
	logic               load_out;
	logic               accept;
	slot_t              ring [SLOT_COUNT];
	slot_t              head_nxt;
	upd_res_t           head_res;

	assign last   = (cnt_q == IDX_W'(SLOT_COUNT - 1));
	assign accept = in_valid && in_ready;

	// Ring of slot cells; the head feeds the tail through the update unit
	for (genvar i = 0; i < SLOT_COUNT; i++) begin : g_cell
		slot_t d;
		if (i == SLOT_COUNT - 1) begin : g_tail
			assign d = head_nxt;
		end else begin : g_mid
			assign d = ring[i+1];
		end
		ptts_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.shift_en (shift_en),
			.d        (d),
			.q        (ring[i])
		);
	end

	ptts_update #(
		.IDX_W (IDX_W)
	) u_update (
		.item (item_q),
		.idx  (cnt_q),
		.cur  (ring[0]),
		.nxt  (head_nxt),
		.res  (head_res)
	);

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: if (in_valid) state_d = S_RUN;
			S_RUN:  if (last) state_d = S_DONE;
			S_DONE: if (!out_valid_q || out_ready) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// Sequencer outputs
	always_comb begin
		in_ready = 1'b0;
		shift_en = 1'b0;
		load_out = 1'b0;
		unique case (state_q)
			S_IDLE: in_ready = 1'b1;
			S_RUN:  shift_en = 1'b1;
			S_DONE: load_out = !out_valid_q || out_ready;
			default: in_ready = 1'b0;
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				cnt_q <= '0;
			end else if (shift_en) begin
				cnt_q <= last ? '0 : cnt_q + IDX_W'(1);
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Capture the word, accumulate the result over the sweep and load the output register
	always_ff @(posedge clk) begin
		if (accept) begin
			item_q   <= in_data;
			mask_q   <= '0;
			status_q <= 1'b0;
		end else if (shift_en) begin
			mask_q   <= mask_q | (MASK_W'(head_res.fire) << cnt_q);
			status_q <= status_q | head_res.taken;
		end
		if (load_out) begin
			out_q.status    <= status_q;
			out_q.fire_mask <= mask_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

// File: hdl/ptts_cell.sv
module ptts_cell (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            shift_en,
	input  ptts_pkg::slot_t d,
	output ptts_pkg::slot_t q
);
	import ptts_pkg::*;

	slot_t slot_q;

	// Take the neighbor's slot state on every shift
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q <= '0;
		end else if (shift_en) begin
			slot_q <= d;
		end
	end

	assign q = slot_q;

endmodule

// File: hdl/ptts_update.sv
module ptts_update #(
	parameter int IDX_W = 3
) (
	input  ptts_pkg::in_t      item,
	input  logic [IDX_W-1:0]   idx,
	input  ptts_pkg::slot_t    cur,
	output ptts_pkg::slot_t    nxt,
	output ptts_pkg::upd_res_t res
);
	import ptts_pkg::*;

	logic match;

	assign match = (32'(item.slot) == 32'(idx));

	// Apply the operation to the slot passing the head of the ring
	always_comb begin
		nxt = cur;
		res = '0;
		if (item.operation == OP_TICK) begin
			if (cur.present && cur.resumed) begin
				if (cur.countdown == 16'd0) begin
					nxt.countdown = cur.period - 16'd1;
					res.fire      = 1'b1;
				end else begin
					nxt.countdown = cur.countdown - 16'd1;
				end
			end
		end else if (match) begin
			case (item.operation)
				OP_CREATE: begin
					if (cur.present) begin
						res.taken = 1'b1;
					end else begin
						nxt.present   = 1'b1;
						nxt.resumed   = 1'b1;
						nxt.period    = item.period;
						nxt.countdown = item.first_delay;
					end
				end
				OP_DELETE:  nxt.present = 1'b0;
				OP_SUSPEND: nxt.resumed = 1'b0;
				OP_RESUME:  nxt.resumed = 1'b1;
				default:    nxt = cur;
			endcase
		end
	end

endmodule
